>>> rtl/assert_macros.svh
// Assertion macros used by the shape fill rasterizer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SFR_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define SFR_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define SFR_ASSERT(name, clk, rst_n, prop)
`define SFR_ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

>>> rtl/sfr_pkg.sv
// Shared types, constants and helpers of the shape fill rasterizer.
`timescale 1ns / 1ps
package sfr_pkg;

  localparam int unsigned CANVAS_SIDE_DEF = 400;
  localparam int unsigned CANVAS_SIDE_MAX = 1024;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] WHITE_LEVEL = 8'd255;

  // Signed coordinates wide enough for a box edge plus twice a radius.
  localparam int unsigned COORD_W = 13;
  // Squared distances inside any circle bounding box.
  localparam int unsigned SQ_W    = 24;
  // Pixel address of the largest canvas.
  localparam int unsigned ADDR_W  = $clog2(CANVAS_SIDE_MAX * CANVAS_SIDE_MAX);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [SQ_W-1:0]           sq_t;
  typedef logic [ADDR_W-1:0]         addr_t;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_RECT   = 3'd1,
    OP_TRI    = 3'd2,
    OP_CIRCLE = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    K_RECT = 2'd0,
    K_TRI  = 2'd1,
    K_CIRC = 2'd2,
    K_READ = 2'd3
  } kind_e;

  // One classified command as it travels from the front end to the raster engine.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] gray;
    logic       offgrid;
    coord_t     xa;
    coord_t     xb;
    coord_t     ya;
    coord_t     yb;
    coord_t     lo;
    coord_t     hi;
    coord_t     dx0;
    coord_t     dy0;
    sq_t        dx0sq;
    sq_t        dy0sq;
    sq_t        rr;
    addr_t      base;
  } job_t;

  typedef struct packed {
    logic init_busy;
    logic idle;
  } bk_status_t;

  function automatic coord_t clamp_side(coord_t v, coord_t side);
    coord_t r;
    if (v < 0) begin
      r = '0;
    end else if (v > side) begin
      r = side;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> rtl/sfr_cmd_if.sv
// Command channel: one drawing or read command per item.
`timescale 1ns / 1ps
interface sfr_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic signed [10:0] x_pos;
  logic signed [10:0] y_pos;
  logic [9:0]         extent_a;
  logic [9:0]         extent_b;
  logic [7:0]         gray;

  modport source (output valid, op, x_pos, y_pos, extent_a, extent_b, gray, input ready);
  modport sink   (input valid, op, x_pos, y_pos, extent_a, extent_b, gray, output ready);
endinterface

>>> rtl/sfr_pix_if.sv
// Result channel: one pixel value per item.
`timescale 1ns / 1ps
interface sfr_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_value;

  modport source (output valid, pixel_value, input ready);
  modport sink   (input valid, pixel_value, output ready);
endinterface

>>> rtl/shape_fill_rasterizer.sv
// Top level of the grey-level frame buffer shape fill rasterizer.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
//   cmd_i carries one command per item: clear, rectangle, triangle, circle or
//   pixel read. Only a read produces an item on pix_o, in command order.
//   A command is classified in the front end (F_BOUND, F_MUL1, F_MUL2) and
//   queued in F_PUSH; the front end takes no new command until it is queued.
//   The raster engine then walks one pixel per cycle over the clipped bounding
//   box (per row of a triangle), writing the pixels inside the shape, with a
//   B_ROW setup state before each row.
//   The rate is set by the single write port of the frame memory.
//   A read passes the front end and the queue; the engine reads the frame
//   memory into a data register, then loads the pix_o output register; a read
//   off the canvas skips the memory and loads 0 into the output register.
//   After reset the engine sweeps the whole frame to white, one pixel a cycle;
//   cmd_i.ready stays low until the sweep ends.
//   pix_o has an output register: if the receiver stalls, the result waits
//   there and shapes keep drawing; a later read waits for that register.
module shape_fill_rasterizer import sfr_pkg::*; #(
  parameter int unsigned CANVAS_SIDE = CANVAS_SIDE_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfr_cmd_if.sink    cmd_i,
  sfr_pix_if.source  pix_o
);

  logic       front_ready;
  logic       front_valid;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  job_t       q_in;
  job_t       q_out;
  bk_status_t bk_status;

  assign front_valid = cmd_i.valid && !bk_status.init_busy;
  assign cmd_i.ready = front_ready && !bk_status.init_busy;

  sfr_front #(
    .CANVAS_SIDE(CANVAS_SIDE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (front_valid),
    .ready_o    (front_ready),
    .op_i       (cmd_i.op),
    .x_pos_i    (cmd_i.x_pos),
    .y_pos_i    (cmd_i.y_pos),
    .extent_a_i (cmd_i.extent_a),
    .extent_b_i (cmd_i.extent_b),
    .gray_i     (cmd_i.gray),
    .push_o     (q_push),
    .job_o      (q_in),
    .full_i     (q_full)
  );

  sfr_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  sfr_back #(
    .CANVAS_SIDE(CANVAS_SIDE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (q_out),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .pix_valid_o (pix_o.valid),
    .pix_value_o (pix_o.pixel_value),
    .pix_ready_i (pix_o.ready),
    .status_o    (bk_status)
  );

  // The reset sweep runs once; nothing brings it back short of reset.
  `SFR_ASSERT(a_init_once, clk_i, rst_ni, !bk_status.init_busy |=> !bk_status.init_busy)
  // The engine takes a job only from a non-empty queue and only between jobs.
  `SFR_ASSERT(a_pop_idle, clk_i, rst_ni, q_pop |-> (bk_status.idle && !q_empty))
  `SFR_ASSERT_NEVER(a_push_full, clk_i, rst_ni, q_push && q_full)

endmodule

>>> rtl/sfr_fifo.sv
// Short job queue between the command front end and the raster engine.
`timescale 1ns / 1ps
module sfr_fifo import sfr_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            slot_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (pop_i && !push_i) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/sfr_front.sv
// Command front end: takes a command, works out clipped bounds and products, queues a job.
`timescale 1ns / 1ps
module sfr_front import sfr_pkg::*; #(
  parameter int unsigned CANVAS_SIDE = CANVAS_SIDE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [2:0]         op_i,
  input  logic signed [10:0] x_pos_i,
  input  logic signed [10:0] y_pos_i,
  input  logic [9:0]         extent_a_i,
  input  logic [9:0]         extent_b_i,
  input  logic [7:0]         gray_i,
  output logic               push_o,
  output job_t               job_o,
  input  logic               full_i
);

  localparam coord_t SideC = coord_t'(CANVAS_SIDE);

  typedef enum logic [4:0] {
    F_IDLE  = 5'b00001,
    F_BOUND = 5'b00010,
    F_MUL1  = 5'b00100,
    F_MUL2  = 5'b01000,
    F_PUSH  = 5'b10000
  } fstate_e;

  fstate_e            state_q, state_d;
  logic [2:0]         op_q;
  logic signed [10:0] x_q;
  logic signed [10:0] y_q;
  logic [9:0]         ea_q;
  logic [9:0]         eb_q;
  logic [7:0]         gray_q;
  job_t               job_q;

  coord_t      x0, y0, ea, eb, half, two_r, apex, k0;
  coord_t      bx0, bx1, by0, by1;
  kind_e       kind;
  logic [7:0]  gray;
  logic [19:0] rr_w;
  addr_t       base_w;
  logic signed [2*COORD_W-1:0] dx0sq_w, dy0sq_w;

  assign ready_o = (state_q == F_IDLE);
  assign push_o  = (state_q == F_PUSH) && !full_i;
  assign job_o   = job_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        // Unused op codes are taken and dropped here.
        if (valid_i && (op_i <= OP_READ)) begin
          state_d = F_BOUND;
        end
      end
      F_BOUND: state_d = F_MUL1;
      F_MUL1:  state_d = F_MUL2;
      F_MUL2:  state_d = F_PUSH;
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Bounding box of each command, before clipping.
  always_comb begin
    x0    = coord_t'(x_q);
    y0    = coord_t'(y_q);
    ea    = $signed({3'b000, ea_q});
    eb    = $signed({3'b000, eb_q});
    half  = $signed({4'b0000, ea_q[9:1]});
    two_r = $signed({2'b00, ea_q, 1'b0});
    apex  = x0 + half;
    k0    = (y0 < 0) ? -y0 : '0;
    bx0   = x0;
    bx1   = x0;
    by0   = y0;
    by1   = y0;
    kind  = K_RECT;
    gray  = gray_q;
    unique case (op_e'(op_q))
      OP_CLEAR: begin
        bx0  = '0;
        bx1  = SideC;
        by0  = '0;
        by1  = SideC;
        gray = WHITE_LEVEL;
      end
      OP_RECT: begin
        bx1 = x0 + ea;
        by1 = y0 + eb;
      end
      OP_TRI: begin
        by1  = y0 + half;
        kind = K_TRI;
      end
      OP_CIRCLE: begin
        bx1  = x0 + two_r;
        by1  = y0 + two_r;
        kind = K_CIRC;
      end
      OP_READ: begin
        kind = K_READ;
      end
      default: begin
        kind = K_RECT;
      end
    endcase
  end

  always_comb begin
    rr_w    = 20'(ea_q) * 20'(ea_q);
    base_w  = addr_t'(job_q.ya[10:0]) * addr_t'(CANVAS_SIDE);
    if (job_q.kind == K_READ) begin
      base_w = base_w + addr_t'(job_q.xa[10:0]);
    end
    dx0sq_w = job_q.dx0 * job_q.dx0;
    dy0sq_w = job_q.dy0 * job_q.dy0;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && valid_i) begin
      op_q   <= op_i;
      x_q    <= x_pos_i;
      y_q    <= y_pos_i;
      ea_q   <= extent_a_i;
      eb_q   <= extent_b_i;
      gray_q <= gray_i;
    end
    if (state_q == F_BOUND) begin
      job_q.kind    <= kind;
      job_q.gray    <= gray;
      job_q.offgrid <= (x0 < 0) || (x0 >= SideC) || (y0 < 0) || (y0 >= SideC);
      job_q.xa      <= clamp_side(bx0, SideC);
      job_q.xb      <= clamp_side(bx1, SideC);
      job_q.ya      <= clamp_side(by0, SideC);
      job_q.yb      <= clamp_side(by1, SideC);
      // Triangle span on the first visible row.
      job_q.lo      <= apex - k0;
      job_q.hi      <= apex + k0 + coord_t'(1);
      // Offsets from the circle centre at the first visible column and row.
      job_q.dx0     <= (x0 < 0) ? -(x0 + ea) : -ea;
      job_q.dy0     <= (y0 < 0) ? -(y0 + ea) : -ea;
    end
    if (state_q == F_MUL1) begin
      job_q.rr   <= sq_t'(rr_w);
      job_q.base <= base_w;
    end
    if (state_q == F_MUL2) begin
      job_q.dx0sq <= dx0sq_w[SQ_W-1:0];
      job_q.dy0sq <= dy0sq_w[SQ_W-1:0];
    end
  end

endmodule

>>> rtl/sfr_back.sv
// Raster engine: walks each job row by row over the frame memory and answers reads.
`timescale 1ns / 1ps
module sfr_back import sfr_pkg::*; #(
  parameter int unsigned CANVAS_SIDE = CANVAS_SIDE_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  job_t       job_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       pix_valid_o,
  output logic [7:0] pix_value_o,
  input  logic       pix_ready_i,
  output bk_status_t status_o
);

  localparam int unsigned Depth = CANVAS_SIDE * CANVAS_SIDE;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(CANVAS_SIDE + 1);
  localparam coord_t      SideC = coord_t'(CANVAS_SIDE);

  typedef enum logic [4:0] {
    B_INIT = 5'b00001,
    B_IDLE = 5'b00010,
    B_ROW  = 5'b00100,
    B_SPAN = 5'b01000,
    B_READ = 5'b10000
  } bstate_e;

  logic [7:0] frame_mem [Depth];

  bstate_e       state_q, state_d;
  logic          init_q;
  kind_e         kind_q;
  logic [7:0]    gray_q;
  logic [CW-1:0] xa_q, xb_q, x_q, xe_q, y_q, yb_q;
  coord_t        lo_q, hi_q, dx0_q, dx_q, dy_q;
  sq_t           dx0sq_q, dxsq_q, dysq_q, rr_q;
  logic [AW-1:0] base_q, addr_q;
  logic [7:0]    rdata_q;
  logic          pix_valid_q;
  logic [7:0]    pix_q;

  logic          out_free, row_done, span_ok, span_last, in_shape, wr_en, rd_en;
  logic [CW-1:0] row_xa, row_xb;
  coord_t        lo_clip, hi_clip;
  logic [SQ_W:0] dist_sq;

  assign out_free  = !pix_valid_q || pix_ready_i;
  assign row_done  = (y_q >= yb_q);
  assign lo_clip   = clamp_side(lo_q, SideC);
  assign hi_clip   = clamp_side(hi_q, SideC);
  assign row_xa    = (kind_q == K_TRI) ? lo_clip[CW-1:0] : xa_q;
  assign row_xb    = (kind_q == K_TRI) ? hi_clip[CW-1:0] : xb_q;
  assign span_ok   = (row_xa < row_xb);
  assign span_last = (CW'(x_q + 1'b1) == xe_q);
  assign dist_sq   = {1'b0, dxsq_q} + {1'b0, dysq_q};
  assign in_shape  = (kind_q != K_CIRC) || (dist_sq <= {1'b0, rr_q});
  assign wr_en     = (state_q == B_SPAN) && in_shape;
  assign pop_o     = (state_q == B_IDLE) && !empty_i && ((job_i.kind != K_READ) || out_free);
  assign rd_en     = pop_o && (job_i.kind == K_READ) && !job_i.offgrid;

  assign pix_valid_o        = pix_valid_q;
  assign pix_value_o        = pix_q;
  assign status_o.init_busy = init_q;
  assign status_o.idle      = (state_q == B_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_INIT: state_d = B_ROW;
      B_IDLE: begin
        if (pop_o) begin
          if (job_i.kind != K_READ) begin
            state_d = B_ROW;
          end else if (!job_i.offgrid) begin
            state_d = B_READ;
          end
        end
      end
      B_ROW: begin
        if (row_done) begin
          state_d = B_IDLE;
        end else if (span_ok) begin
          state_d = B_SPAN;
        end
      end
      B_SPAN: begin
        if (span_last) begin
          state_d = B_ROW;
        end
      end
      B_READ:  state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_INIT;
      init_q      <= 1'b1;
      pix_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_ROW && row_done) begin
        init_q <= 1'b0;
      end
      if (state_q == B_READ || (pop_o && job_i.kind == K_READ && job_i.offgrid)) begin
        pix_valid_q <= 1'b1;
      end else if (pix_ready_i) begin
        pix_valid_q <= 1'b0;
      end
    end
  end

  // Job walk: a row setup state (B_ROW), then one pixel per cycle across the visible span.
  always_ff @(posedge clk_i) begin
    if (state_q == B_READ) begin
      pix_q <= rdata_q;
    end else if (pop_o && job_i.kind == K_READ && job_i.offgrid) begin
      pix_q <= '0;
    end
    unique case (state_q)
      B_INIT: begin
        // The reset sweep is a full-canvas white rectangle.
        kind_q <= K_RECT;
        gray_q <= WHITE_LEVEL;
        xa_q   <= '0;
        xb_q   <= CW'(CANVAS_SIDE);
        y_q    <= '0;
        yb_q   <= CW'(CANVAS_SIDE);
        base_q <= '0;
      end
      B_IDLE: begin
        if (pop_o && job_i.kind != K_READ) begin
          kind_q  <= job_i.kind;
          gray_q  <= job_i.gray;
          xa_q    <= job_i.xa[CW-1:0];
          xb_q    <= job_i.xb[CW-1:0];
          y_q     <= job_i.ya[CW-1:0];
          yb_q    <= job_i.yb[CW-1:0];
          lo_q    <= job_i.lo;
          hi_q    <= job_i.hi;
          dx0_q   <= job_i.dx0;
          dx0sq_q <= job_i.dx0sq;
          dy_q    <= job_i.dy0;
          dysq_q  <= job_i.dy0sq;
          rr_q    <= job_i.rr;
          base_q  <= job_i.base[AW-1:0];
        end
      end
      B_ROW: begin
        if (!row_done) begin
          if (span_ok) begin
            x_q    <= row_xa;
            xe_q   <= row_xb;
            addr_q <= base_q + AW'(row_xa);
            dx_q   <= dx0_q;
            dxsq_q <= dx0sq_q;
          end else begin
            y_q    <= CW'(y_q + 1'b1);
            base_q <= AW'(base_q + AW'(CANVAS_SIDE));
            lo_q   <= lo_q - coord_t'(1);
            hi_q   <= hi_q + coord_t'(1);
            dy_q   <= dy_q + coord_t'(1);
            dysq_q <= dysq_q + sq_t'($signed({dy_q, 1'b1}));
          end
        end
      end
      B_SPAN: begin
        x_q    <= CW'(x_q + 1'b1);
        addr_q <= AW'(addr_q + 1'b1);
        dx_q   <= dx_q + coord_t'(1);
        dxsq_q <= dxsq_q + sq_t'($signed({dx_q, 1'b1}));
        if (span_last) begin
          y_q    <= CW'(y_q + 1'b1);
          base_q <= AW'(base_q + AW'(CANVAS_SIDE));
          lo_q   <= lo_q - coord_t'(1);
          hi_q   <= hi_q + coord_t'(1);
          dy_q   <= dy_q + coord_t'(1);
          dysq_q <= dysq_q + sq_t'($signed({dy_q, 1'b1}));
        end
      end
      B_READ: begin
        kind_q <= kind_q;
      end
      default: begin
        kind_q <= kind_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      frame_mem[addr_q] <= gray_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= frame_mem[job_i.base[AW-1:0]];
    end
  end

endmodule
